@@ src/coverage_accumulate_blend_core_defines.svh @@
// Assertion macros for the coverage accumulate blend core.
// Taken in by the top level; no other dependencies.
`ifndef COVERAGE_ACCUMULATE_BLEND_CORE_DEFINES_SVH
`define COVERAGE_ACCUMULATE_BLEND_CORE_DEFINES_SVH
`ifndef SYNTH
// same-cycle implication
`define CAB_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cab: same-cycle check failed");
// next-cycle implication
`define CAB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cab: next-cycle check failed");
`else
`define CAB_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define CAB_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

@@ src/cab_pkg.sv @@
// Shared types and constants of the coverage accumulate blend core.
// No dependencies; used by the front, back and top level.
`default_nettype none
package cab_pkg;

   // configuration register indexes
   localparam logic [2:0] REG_ROW_WIDTH    = 3'd0;
   localparam logic [2:0] REG_FRAME_HEIGHT = 3'd1;
   localparam logic [2:0] REG_ROW_STRIDE   = 3'd2;
   localparam logic [2:0] REG_CLIP_LEFT    = 3'd3;
   localparam logic [2:0] REG_CLIP_RIGHT   = 3'd4;

   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 13;

   // register reset values
   localparam logic [12:0] RESET_ROW_WIDTH    = 13'd640;
   localparam logic [12:0] RESET_FRAME_HEIGHT = 13'd480;
   localparam logic [12:0] RESET_ROW_STRIDE   = 13'd640;
   localparam logic [12:0] RESET_CLIP_LEFT    = 13'd0;
   localparam logic [12:0] RESET_CLIP_RIGHT   = 13'd640;

   // column counter stops here when a row never ends
   localparam logic [12:0] COL_MAX = 13'd8191;

   // alpha field holds 1.0 at the widest supported fraction
   localparam int ALPHA_W = 25;

   // output queue depth
   localparam int OUT_DEPTH = 2;

   typedef struct packed {
      logic                     en;
      logic [CSR_IDX_W-1:0]     index;
      logic [CSR_DATA_W-1:0]    data;
   } csr_write_type;

   // classified pixel handed from front to back
   typedef struct packed {
      logic                draw;
      logic [ALPHA_W-1:0]  alpha;
      logic [7:0]          red;
      logic [7:0]          green;
      logic [7:0]          blue;
      logic [7:0]          brush_a;
      logic [31:0]         dest;
      logic [23:0]         addr;
      logic                last;
   } mid_entry_type;

   // finished result
   typedef struct packed {
      logic        write_enable;
      logic [23:0] pixel_address;
      logic [31:0] pixel_value;
      logic        row_done;
   } rsp_entry_type;

endpackage
`default_nettype wire

@@ src/cab_fifo.sv @@
// Small register queue used between front and back and at the result side.
// Depends on nothing.
`default_nettype none
module cab_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output      logic             full,
   input  wire logic             pop,
   output      logic [WIDTH-1:0] pop_data,
   output      logic             empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem[rd_ptr_ff];

   // pointer and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      count_in = count_ff + CW'(do_push) - CW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage, no reset
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

@@ src/cab_front.sv @@
// Front part: configuration registers, coverage sum, column counter,
// clip and frame tests and pixel address. Depends on cab_pkg.
`default_nettype none
module cab_front #(
   parameter int COVERAGE_FRAC_BITS = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire cab_pkg::csr_write_type csr,
   input  wire logic                   accept,
   input  wire logic signed [23:0]     coverage_delta,
   input  wire logic [31:0]            dest_pixel,
   input  wire logic [7:0]             brush_red,
   input  wire logic [7:0]             brush_green,
   input  wire logic [7:0]             brush_blue,
   input  wire logic [7:0]             brush_alpha,
   input  wire logic [11:0]            row_index,
   input  wire logic                   last_in_row,
   output      cab_pkg::mid_entry_type entry
);

   localparam int F = COVERAGE_FRAC_BITS;
   localparam logic [31:0] ONE = 32'd1 << F;
   localparam logic [31:0] ALPHA_MIN = ONE >> 8;

   logic [12:0] row_width_ff, frame_height_ff, row_stride_ff;
   logic [12:0] clip_left_ff, clip_right_ff;
   logic signed [31:0] sum_ff, sum_in;
   logic [12:0] col_ff, col_in;

   logic signed [32:0] sum_wide;
   logic signed [31:0] sum_sat;
   logic [31:0] mag, alpha;
   logic [24:0] addr_prod;
   logic [24:0] addr_full;
   logic        row_ok, col_ok;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         row_width_ff    <= cab_pkg::RESET_ROW_WIDTH;
         frame_height_ff <= cab_pkg::RESET_FRAME_HEIGHT;
         row_stride_ff   <= cab_pkg::RESET_ROW_STRIDE;
         clip_left_ff    <= cab_pkg::RESET_CLIP_LEFT;
         clip_right_ff   <= cab_pkg::RESET_CLIP_RIGHT;
      end else if (csr.en) begin
         unique case (csr.index)
            cab_pkg::REG_ROW_WIDTH:    row_width_ff    <= csr.data;
            cab_pkg::REG_FRAME_HEIGHT: frame_height_ff <= csr.data;
            cab_pkg::REG_ROW_STRIDE:   row_stride_ff   <= csr.data;
            cab_pkg::REG_CLIP_LEFT:    clip_left_ff    <= csr.data;
            cab_pkg::REG_CLIP_RIGHT:   clip_right_ff   <= csr.data;
            default: ;
         endcase
      end
   end

   // saturating coverage sum and its clamped magnitude
   always_comb begin
      sum_wide = {sum_ff[31], sum_ff} + {{9{coverage_delta[23]}}, coverage_delta};
      if (sum_wide[32] != sum_wide[31]) begin
         sum_sat = sum_wide[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
         sum_sat = sum_wide[31:0];
      end
      mag   = sum_sat[31] ? (~sum_sat + 32'd1) : sum_sat;
      alpha = (mag >= ONE) ? ONE : mag;
   end

   // window tests and address
   always_comb begin
      row_ok    = ({1'b0, row_index} < frame_height_ff);
      col_ok    = (col_ff >= clip_left_ff) && (col_ff < clip_right_ff)
                  && (col_ff < row_width_ff);
      addr_prod = {13'd0, row_index} * {12'd0, row_stride_ff};
      addr_full = addr_prod + {12'd0, col_ff};
   end

   // classified entry for the queue
   always_comb begin
      entry.draw    = row_ok && col_ok && (alpha >= ALPHA_MIN);
      entry.alpha   = alpha[cab_pkg::ALPHA_W-1:0];
      entry.red     = brush_red;
      entry.green   = brush_green;
      entry.blue    = brush_blue;
      entry.brush_a = brush_alpha;
      entry.dest    = dest_pixel;
      entry.addr    = addr_full[23:0];
      entry.last    = last_in_row;
   end

   // row state advance
   always_comb begin
      sum_in = sum_ff;
      col_in = col_ff;
      if (accept) begin
         if (last_in_row) begin
            sum_in = '0;
            col_in = '0;
         end else begin
            sum_in = sum_sat;
            if (col_ff != cab_pkg::COL_MAX) begin
               col_in = col_ff + 13'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
         col_ff <= '0;
      end else begin
         sum_ff <= sum_in;
         col_ff <= col_in;
      end
   end

endmodule
`default_nettype wire

@@ src/cab_back.sv @@
// Back part: three-stage blend pipeline (scaled alpha, channel products,
// divide by 255 and pack). Depends on cab_pkg.
`default_nettype none
module cab_back #(
   parameter int COVERAGE_FRAC_BITS = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   in_valid,
   input  wire cab_pkg::mid_entry_type in_entry,
   output      logic                   in_pop,
   output      logic                   out_push,
   output      cab_pkg::rsp_entry_type out_entry,
   input  wire logic                   out_full
);

   localparam int F = COVERAGE_FRAC_BITS;

   // rounded x / 255 already offset by 127; exact for x below 65280
   function automatic logic [7:0] div255(input logic [15:0] x);
      logic [16:0] t;
      t = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
      return t[15:8];
   endfunction

   logic en;
   logic v1_ff, v2_ff, v3_ff;

   // stage 1: scaled alpha
   logic [F+8:0] sa_prod;
   logic [7:0]   s1_sa_ff;
   logic         s1_draw_ff;
   logic [7:0]   s1_r_ff, s1_g_ff, s1_b_ff;
   logic [31:0]  s1_dest_ff;
   logic [23:0]  s1_addr_ff;
   logic         s1_last_ff;

   // stage 2: channel products
   logic [7:0]   inv;
   logic [15:0]  s2_r_ff, s2_g_ff, s2_b_ff, s2_a_ff;
   logic [7:0]   s2_sa_ff;
   logic         s2_we_ff;
   logic [31:0]  s2_dest_ff;
   logic [23:0]  s2_addr_ff;
   logic         s2_last_ff;

   // stage 3: packed result
   logic [8:0]   a_sum;
   logic [7:0]   a_val;
   cab_pkg::rsp_entry_type s3_ff;

   // whole pipe holds when the last stage cannot leave
   assign en        = !(v3_ff && out_full);
   assign in_pop    = en && in_valid;
   assign out_push  = v3_ff && !out_full;
   assign out_entry = s3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   assign sa_prod = {8'd0, in_entry.alpha[F:0]} * {{(F+1){1'b0}}, in_entry.brush_a};

   always_ff @(posedge clock) begin
      if (en) begin
         s1_sa_ff   <= sa_prod[F+7:F];
         s1_draw_ff <= in_entry.draw;
         s1_r_ff    <= in_entry.red;
         s1_g_ff    <= in_entry.green;
         s1_b_ff    <= in_entry.blue;
         s1_dest_ff <= in_entry.dest;
         s1_addr_ff <= in_entry.addr;
         s1_last_ff <= in_entry.last;
      end
   end

   assign inv = 8'd255 - s1_sa_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         s2_r_ff    <= {8'd0, s1_r_ff} * {8'd0, s1_sa_ff}
                       + {8'd0, s1_dest_ff[7:0]} * {8'd0, inv} + 16'd127;
         s2_g_ff    <= {8'd0, s1_g_ff} * {8'd0, s1_sa_ff}
                       + {8'd0, s1_dest_ff[15:8]} * {8'd0, inv} + 16'd127;
         s2_b_ff    <= {8'd0, s1_b_ff} * {8'd0, s1_sa_ff}
                       + {8'd0, s1_dest_ff[23:16]} * {8'd0, inv} + 16'd127;
         s2_a_ff    <= {8'd0, s1_dest_ff[31:24]} * {8'd0, inv} + 16'd127;
         s2_sa_ff   <= s1_sa_ff;
         s2_we_ff   <= s1_draw_ff && (s1_sa_ff != 8'd0);
         s2_dest_ff <= s1_dest_ff;
         s2_addr_ff <= s1_addr_ff;
         s2_last_ff <= s1_last_ff;
      end
   end

   // destination alpha term plus source alpha, clamped
   always_comb begin
      a_sum = {1'b0, s2_sa_ff} + {1'b0, div255(s2_a_ff)};
      a_val = a_sum[8] ? 8'd255 : a_sum[7:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s3_ff.write_enable  <= s2_we_ff;
         s3_ff.pixel_address <= s2_addr_ff;
         s3_ff.row_done      <= s2_last_ff;
         s3_ff.pixel_value   <= s2_we_ff
            ? {a_val, div255(s2_b_ff), div255(s2_g_ff), div255(s2_r_ff)}
            : s2_dest_ff;
      end
   end

endmodule
`default_nettype wire

@@ src/coverage_accumulate_blend_core.sv @@
// Top level of the coverage accumulate blend core.
// Depends on cab_pkg, cab_fifo, cab_front, cab_back and the defines header.
//
//   channel  direction  handshake          payload
//   req_     in         req_push/req_full  delta, dest pixel, brush, row, last
//   rsp_     out        rsp_pop/rsp_empty  write enable, address, value, row done
//   csr_     in         csr_write          csr_index, csr_data (13 bits)
//
// One request accepted per cycle while the front queue has room; a result
// passes through the front queue, the three blend stages and the result queue.
// Reset is synchronous: sum, column count, queues and registers to defaults.
// A stalled result side fills the output and front queues, then raises req_full.
`default_nettype none
`include "coverage_accumulate_blend_core_defines.svh"
module coverage_accumulate_blend_core #(
   parameter int COVERAGE_FRAC_BITS = 16,
   parameter int MID_DEPTH = 4
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_push,
   output      logic                  req_full,
   input  wire logic signed [23:0]    req_coverage_delta,
   input  wire logic [31:0]           req_dest_pixel,
   input  wire logic [7:0]            req_brush_red,
   input  wire logic [7:0]            req_brush_green,
   input  wire logic [7:0]            req_brush_blue,
   input  wire logic [7:0]            req_brush_alpha,
   input  wire logic [11:0]           req_row_index,
   input  wire logic                  req_last_in_row,
   output      logic                  rsp_empty,
   input  wire logic                  rsp_pop,
   output      logic                  rsp_write_enable,
   output      logic [23:0]           rsp_pixel_address,
   output      logic [31:0]           rsp_pixel_value,
   output      logic                  rsp_row_done,
   input  wire logic                  csr_write,
   input  wire logic [2:0]            csr_index,
   input  wire logic [12:0]           csr_data
);

   cab_pkg::csr_write_type csr;
   cab_pkg::mid_entry_type front_entry, mid_entry;
   cab_pkg::rsp_entry_type back_entry, rsp_entry;
   logic accept;
   logic mid_full, mid_empty, mid_pop;
   logic out_push, out_full;

   assign csr.en    = csr_write;
   assign csr.index = csr_index;
   assign csr.data  = csr_data;

   assign req_full = mid_full;
   assign accept   = req_push && !mid_full;

   // classify and accumulate
   cab_front #(
      .COVERAGE_FRAC_BITS(COVERAGE_FRAC_BITS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .csr            (csr),
      .accept         (accept),
      .coverage_delta (req_coverage_delta),
      .dest_pixel     (req_dest_pixel),
      .brush_red      (req_brush_red),
      .brush_green    (req_brush_green),
      .brush_blue     (req_brush_blue),
      .brush_alpha    (req_brush_alpha),
      .row_index      (req_row_index),
      .last_in_row    (req_last_in_row),
      .entry          (front_entry)
   );

   // queue between front and back
   cab_fifo #(
      .WIDTH($bits(cab_pkg::mid_entry_type)),
      .DEPTH(MID_DEPTH)
   ) u_mid_q (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (front_entry),
      .full      (mid_full),
      .pop       (mid_pop),
      .pop_data  (mid_entry),
      .empty     (mid_empty)
   );

   // blend pipeline
   cab_back #(
      .COVERAGE_FRAC_BITS(COVERAGE_FRAC_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (!mid_empty),
      .in_entry  (mid_entry),
      .in_pop    (mid_pop),
      .out_push  (out_push),
      .out_entry (back_entry),
      .out_full  (out_full)
   );

   // result queue
   cab_fifo #(
      .WIDTH($bits(cab_pkg::rsp_entry_type)),
      .DEPTH(cab_pkg::OUT_DEPTH)
   ) u_out_q (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (back_entry),
      .full      (out_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_entry),
      .empty     (rsp_empty)
   );

   assign rsp_write_enable  = rsp_entry.write_enable;
   assign rsp_pixel_address = rsp_entry.pixel_address;
   assign rsp_pixel_value   = rsp_entry.pixel_value;
   assign rsp_row_done      = rsp_entry.row_done;

   // an accepted request is waiting in the front queue next cycle
   `CAB_ASSERT_NEXT(a_req_lands, clock, reset, accept, !mid_empty)
   // back part never takes from an empty front queue
   `CAB_ASSERT_IMPLY(a_pop_nonempty, clock, reset, mid_pop, !mid_empty)
   // back part never pushes into a full result queue
   `CAB_ASSERT_IMPLY(a_push_room, clock, reset, out_push, !out_full)
   // a pushed result makes the result side non-empty
   `CAB_ASSERT_NEXT(a_rsp_shows, clock, reset, out_push, !rsp_empty)

endmodule
`default_nettype wire
